FILE: rtl/core/awt_pkg.sv
// Package with constants, beat types and helpers for the address window table.
`default_nettype none
package awt_pkg;

  localparam int NUM_WINDOWS    = 20;
  localparam int NUM_REMAPPABLE = 8;
  localparam int IDX_W          = 5;
  localparam int REMAP_DEPTH    = (NUM_REMAPPABLE > 0) ? NUM_REMAPPABLE : 1;
  localparam int REMAP_IW       = (REMAP_DEPTH > 1) ? $clog2(REMAP_DEPTH) : 1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_NOFREE   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] window_index;
    logic [31:0]      base_addr;
    logic [31:0]      window_size;
    logic [3:0]       target_id;
    logic [7:0]       attribute;
    logic             use_remap;
    logic [31:0]      remap_base;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic             entry_enabled;
    logic [31:0]      entry_base;
    logic [31:0]      entry_size;
    logic [3:0]       entry_target;
    logic [7:0]       entry_attribute;
    logic [31:0]      entry_remap;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] base_g;
    logic [15:0] size_g;
    logic [3:0]  target;
    logic [7:0]  attribute;
  } entry_t;

  typedef struct packed {
    logic overlap;
    logic tag_hit;
    logic del_hit;
  } match_t;

  function automatic logic [31:0] recon_size(logic [15:0] g);
    return {g, 16'hffff} + 32'd1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/awt_window_unit.sv
// Compare unit that tests one stored window against the current request.
`default_nettype none
module awt_window_unit (
  input  wire awt_pkg::entry_t entry,
  input  wire [31:0]           req_base,
  input  wire [32:0]           req_end,
  input  wire [31:0]           req_size,
  input  wire [3:0]            req_target,
  input  wire [7:0]            req_attribute,
  output awt_pkg::match_t      match
);
  import awt_pkg::*;

  logic [31:0] wsize;
  logic [32:0] wb;
  logic [32:0] we;

  always_comb begin
    wsize = recon_size(entry.size_g);
    wb    = {1'b0, entry.base_g, 16'h0000};
    we    = wb + {1'b0, wsize};
    match.overlap = entry.valid && ({1'b0, req_base} < we) && (req_end > wb);
    match.tag_hit = entry.valid && (entry.target == req_target)
                    && (entry.attribute == req_attribute);
    match.del_hit = entry.valid && ({entry.base_g, 16'h0000} == req_base)
                    && (wsize == req_size);
  end
endmodule
`default_nettype wire

FILE: rtl/core/address_window_table_core.sv
// Top level of the address window table: sequencer, window storage and result register.
// Add and delete scan every window once through one compare unit, then pass through the
// FINISH state before the result strobe. Read passes through the READ state alone.
// busy is high from the accepted start beat until the result is driven; the result is
// shown for one cycle and cannot be stalled. A new start may coincide with the strobe.
// Synchronous reset disables all windows; stored fields of disabled windows read as zero.
`default_nettype none
module address_window_table_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire awt_pkg::cmd_t   cmd,
  output logic                 busy,
  output logic                 result_strobe,
  output awt_pkg::result_t     result
);
  import awt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0]       state;
  cmd_t             cmd_q;
  logic [32:0]      req_end;
  logic [IDX_W-1:0] scan_idx;

  logic             conflict;
  logic             found_hi;
  logic             found_any;
  logic             found_del;
  logic [IDX_W-1:0] hi_slot;
  logic [IDX_W-1:0] any_slot;
  logic [IDX_W-1:0] del_slot;

  logic [NUM_WINDOWS-1:0] win_valid;
  logic [15:0]            win_base_g [NUM_WINDOWS];
  logic [15:0]            win_size_g [NUM_WINDOWS];
  logic [3:0]             win_target [NUM_WINDOWS];
  logic [7:0]             win_attr   [NUM_WINDOWS];
  logic [15:0]            win_remap_g[REMAP_DEPTH];

  entry_t scan_entry;
  match_t match;

  logic             idx_in_range;
  logic [IDX_W-1:0] rd_idx;
  logic             add_ok;
  logic [IDX_W-1:0] add_slot;
  result_t          result_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    scan_entry.valid     = win_valid[scan_idx];
    scan_entry.base_g    = win_base_g[scan_idx];
    scan_entry.size_g    = win_size_g[scan_idx];
    scan_entry.target    = win_target[scan_idx];
    scan_entry.attribute = win_attr[scan_idx];
  end

  awt_window_unit u_unit (
    .entry         (scan_entry),
    .req_base      (cmd_q.base_addr),
    .req_end       (req_end),
    .req_size      (cmd_q.window_size),
    .req_target    (cmd_q.target_id),
    .req_attribute (cmd_q.attribute),
    .match         (match)
  );

  always_comb begin
    idx_in_range = ({27'd0, cmd_q.window_index} < NUM_WINDOWS);
    rd_idx       = idx_in_range ? cmd_q.window_index : '0;
    add_ok       = 1'b0;
    add_slot     = '0;
    if (!cmd_q.use_remap && found_hi) begin
      add_ok   = 1'b1;
      add_slot = hi_slot;
    end else if (found_any) begin
      add_ok   = 1'b1;
      add_slot = any_slot;
    end
  end

  always_comb begin
    result_next = '0;
    if (state == S_FINISH) begin
      if (cmd_q.operation == OP_ADD) begin
        if (conflict) begin
          result_next.status = ST_CONFLICT;
        end else if (!add_ok) begin
          result_next.status = ST_NOFREE;
        end else begin
          result_next.status = ST_OK;
          result_next.slot   = add_slot;
        end
      end else if (found_del) begin
        result_next.status = ST_OK;
        result_next.slot   = del_slot;
      end else begin
        result_next.status = ST_NOTFOUND;
      end
    end else if (cmd_q.operation != OP_READ) begin
      result_next.status = ST_NOTFOUND;
    end else if (!idx_in_range) begin
      result_next.status = ST_NOTFOUND;
      result_next.slot   = cmd_q.window_index;
    end else begin
      result_next.status = ST_OK;
      result_next.slot   = cmd_q.window_index;
      if (win_valid[rd_idx]) begin
        result_next.entry_enabled   = 1'b1;
        result_next.entry_base      = {win_base_g[rd_idx], 16'h0000};
        result_next.entry_size      = recon_size(win_size_g[rd_idx]);
        result_next.entry_target    = win_target[rd_idx];
        result_next.entry_attribute = win_attr[rd_idx];
        if ({27'd0, rd_idx} < NUM_REMAPPABLE) begin
          result_next.entry_remap = {win_remap_g[rd_idx[REMAP_IW-1:0]], 16'h0000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      win_valid     <= '0;
      result_strobe <= 1'b0;
      scan_idx      <= '0;
    end else begin
      result_strobe <= (state == S_FINISH) || (state == S_READ);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q     <= cmd;
            req_end   <= {1'b0, cmd.base_addr} + {1'b0, cmd.window_size};
            scan_idx  <= '0;
            conflict  <= 1'b0;
            found_hi  <= 1'b0;
            found_any <= 1'b0;
            found_del <= 1'b0;
            if (cmd.operation == OP_ADD || cmd.operation == OP_DELETE) begin
              state <= S_SCAN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SCAN: begin
          if (match.overlap || match.tag_hit) begin
            conflict <= 1'b1;
          end
          if (!scan_entry.valid) begin
            if ({27'd0, scan_idx} >= NUM_REMAPPABLE && !found_hi) begin
              found_hi <= 1'b1;
              hi_slot  <= scan_idx;
            end
            if (!found_any) begin
              found_any <= 1'b1;
              any_slot  <= scan_idx;
            end
          end
          if (match.del_hit && !found_del) begin
            found_del <= 1'b1;
            del_slot  <= scan_idx;
          end
          if (scan_idx == IDX_W'(NUM_WINDOWS - 1)) begin
            state <= S_FINISH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_FINISH: begin
          state  <= S_IDLE;
          result <= result_next;
          if (cmd_q.operation == OP_ADD) begin
            if (!conflict && add_ok) begin
              win_valid[add_slot]  <= 1'b1;
              win_base_g[add_slot] <= cmd_q.base_addr[31:16];
              win_size_g[add_slot] <= 16'((cmd_q.window_size - 32'd1) >> 16);
              win_target[add_slot] <= cmd_q.target_id;
              win_attr[add_slot]   <= cmd_q.attribute;
              if ({27'd0, add_slot} < NUM_REMAPPABLE) begin
                win_remap_g[add_slot[REMAP_IW-1:0]] <= cmd_q.use_remap ?
                    cmd_q.remap_base[31:16] : cmd_q.base_addr[31:16];
              end
            end
          end else if (found_del) begin
            win_valid[del_slot] <= 1'b0;
          end
        end
        S_READ: begin
          state  <= S_IDLE;
          result <= result_next;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sim/address_window_table_core_tb.sv
// Self-checking testbench for the address window table core: directed table, then random beats.
module address_window_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import awt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1550;
  localparam int DRAIN_CYCLES = 2 * NUM_WINDOWS + 8;

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t r;
  } stim_row_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    result_strobe;
  result_t result;

  stim_row_t directed[$];
  result_t   pending_results[$];
  int        mismatches = 0;

  logic        win_on[NUM_WINDOWS] = '{default: 1'b0};
  logic [15:0] win_base_g[NUM_WINDOWS] = '{default: 16'h0};
  logic [15:0] win_size_g[NUM_WINDOWS] = '{default: 16'h0};
  logic [3:0]  win_tgt[NUM_WINDOWS] = '{default: 4'h0};
  logic [7:0]  win_attr[NUM_WINDOWS] = '{default: 8'h0};
  logic [15:0] win_remap_g[REMAP_DEPTH] = '{default: 16'h0};

  address_window_table_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .result_strobe(result_strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] granule_span(logic [15:0] g);
    return {g, 16'hffff} + 32'd1;
  endfunction

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic result_t table_outcome(cmd_t c);
    result_t     r;
    int          hit;
    logic [32:0] req_end;
    logic [32:0] w_base;
    logic [32:0] w_end;
    r = '0;
    hit = -1;
    case (c.operation)
      OP_ADD: begin
        req_end = {1'b0, c.base_addr} + {1'b0, c.window_size};
        for (int w = 0; w < NUM_WINDOWS; w++) begin
          if (win_on[w]) begin
            w_base = {1'b0, win_base_g[w], 16'h0};
            w_end = w_base + {1'b0, granule_span(win_size_g[w])};
            if (({1'b0, c.base_addr} < w_end && req_end > w_base) ||
                (c.target_id == win_tgt[w] && c.attribute == win_attr[w])) begin
              r.status = ST_CONFLICT;
              return r;
            end
          end
        end
        if (!c.use_remap) begin
          for (int w = NUM_REMAPPABLE; w < NUM_WINDOWS; w++)
            if (hit < 0 && !win_on[w]) hit = w;
        end
        for (int w = 0; w < NUM_WINDOWS; w++)
          if (hit < 0 && !win_on[w]) hit = w;
        if (hit < 0) begin
          r.status = ST_NOFREE;
          return r;
        end
        win_on[hit] = 1'b1;
        win_base_g[hit] = c.base_addr[31:16];
        win_size_g[hit] = 16'((c.window_size - 32'd1) >> 16);
        win_tgt[hit] = c.target_id;
        win_attr[hit] = c.attribute;
        if (hit < NUM_REMAPPABLE)
          win_remap_g[hit] = c.use_remap ? c.remap_base[31:16] : c.base_addr[31:16];
        r.status = ST_OK;
        r.slot = hit[IDX_W-1:0];
      end
      OP_DELETE: begin
        for (int w = 0; w < NUM_WINDOWS; w++)
          if (hit < 0 && win_on[w] && {win_base_g[w], 16'h0} == c.base_addr &&
              granule_span(win_size_g[w]) == c.window_size)
            hit = w;
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
          return r;
        end
        win_on[hit] = 1'b0;
        win_base_g[hit] = '0;
        win_size_g[hit] = '0;
        win_tgt[hit] = '0;
        win_attr[hit] = '0;
        if (hit < NUM_REMAPPABLE) win_remap_g[hit] = '0;
        r.status = ST_OK;
        r.slot = hit[IDX_W-1:0];
      end
      OP_READ: begin
        r.slot = c.window_index;
        if (c.window_index >= NUM_WINDOWS) begin
          r.status = ST_NOTFOUND;
          return r;
        end
        hit = int'(c.window_index);
        r.status = ST_OK;
        if (win_on[hit]) begin
          r.entry_enabled = 1'b1;
          r.entry_base = {win_base_g[hit], 16'h0};
          r.entry_size = granule_span(win_size_g[hit]);
          r.entry_target = win_tgt[hit];
          r.entry_attribute = win_attr[hit];
          if (hit < NUM_REMAPPABLE) r.entry_remap = {win_remap_g[hit], 16'h0};
        end
      end
      default: r.status = ST_NOTFOUND;
    endcase
    return r;
  endfunction

  function automatic int any_live_window();
    int ids[$];
    foreach (win_on[w])
      if (win_on[w]) ids.push_back(w);
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, logic [4:0] idx, logic [31:0] base,
                                    logic [31:0] size, logic [3:0] tgt, logic [7:0] attr,
                                    logic remap_en, logic [31:0] remap);
    cmd_t c;
    c.operation = op;
    c.window_index = idx;
    c.base_addr = base;
    c.window_size = size;
    c.target_id = tgt;
    c.attribute = attr;
    c.use_remap = remap_en;
    c.remap_base = remap;
    return c;
  endfunction

  function automatic result_t brief_result(logic [1:0] st, logic [4:0] sl);
    result_t r;
    r = '0;
    r.status = st;
    r.slot = sl;
    return r;
  endfunction

  task automatic add_row(cmd_t c, bit typed, result_t r);
    stim_row_t row;
    row.c = c;
    row.typed = typed;
    row.r = r;
    directed.push_back(row);
  endtask

  task automatic build_directed();
    add_row(make_cmd(OP_READ, 5'd0, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_OK, 5'd0));
    add_row(make_cmd(OP_READ, 5'd31, 32'hffffffff, 32'hffffffff, 4'hf, 8'hff, 1'b1,
                     32'hffffffff), 1, brief_result(ST_NOTFOUND, 5'd31));
    add_row(make_cmd(OP_READ, 5'd20, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_NOTFOUND, 5'd20));
    add_row(make_cmd(OP_UNUSED, 5'd5, 32'h1234_0000, 32'h10000, 4'h3, 8'h77, 1'b1,
                     32'h5555_0000), 1, brief_result(ST_NOTFOUND, 5'd0));
    add_row(make_cmd(OP_DELETE, 5'd0, 32'h0, 32'h10000, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_NOTFOUND, 5'd0));
    add_row(make_cmd(OP_ADD, 5'd0, 32'h0, 32'h10000, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_OK, 5'd8));
    add_row(make_cmd(OP_ADD, 5'd0, 32'h0000_ffff, 32'h2, 4'h1, 8'h1, 1'b0, 32'h0), 1,
            brief_result(ST_CONFLICT, 5'd0));
    add_row(make_cmd(OP_ADD, 5'd0, 32'h0100_0000, 32'h10000, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_CONFLICT, 5'd0));
    add_row(make_cmd(OP_ADD, 5'd0, 32'h0001_0000, 32'h10000, 4'h1, 8'h2, 1'b1,
                     32'hffff_1234), 1, brief_result(ST_OK, 5'd0));
    add_row(make_cmd(OP_READ, 5'd0, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_READ, 5'd8, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_ADD, 5'd0, 32'hffff_0000, 32'h0, 4'h2, 8'h3, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_READ, 5'd9, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_ADD, 5'd0, 32'h2000_0000, 32'h1000, 4'h3, 8'h4, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_ADD, 5'd0, 32'h3000_0000, 32'h10000, 4'h2, 8'h3, 1'b0, 32'h0), 1,
            brief_result(ST_CONFLICT, 5'd0));
    add_row(make_cmd(OP_ADD, 5'd31, 32'hffffffff, 32'hffffffff, 4'hf, 8'hff, 1'b1,
                     32'hffffffff), 0, '0);
    add_row(make_cmd(OP_READ, 5'd1, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_READ, 5'd10, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_DELETE, 5'd0, 32'h0001_0000, 32'h10001, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_NOTFOUND, 5'd0));
    add_row(make_cmd(OP_DELETE, 5'd0, 32'h0, 32'h10000, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_OK, 5'd8));
    add_row(make_cmd(OP_DELETE, 5'd0, 32'h0, 32'h10000, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_NOTFOUND, 5'd0));
    add_row(make_cmd(OP_DELETE, 5'd0, 32'hffff_0000, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
    add_row(make_cmd(OP_READ, 5'd8, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 1,
            brief_result(ST_OK, 5'd8));
    add_row(make_cmd(OP_READ, 5'd19, 32'h0, 32'h0, 4'h0, 8'h0, 1'b0, 32'h0), 0, '0);
  endtask

  // Add-heavy and delete-heavy stretches alternate so that the table fills up and drains.
  function automatic cmd_t random_beat(int n);
    cmd_t c;
    int   roll;
    int   live;
    bit   del_phase;
    c.operation = 2'($urandom);
    c.window_index = 5'($urandom);
    c.base_addr = $urandom;
    c.window_size = $urandom;
    c.target_id = 4'($urandom);
    c.attribute = 8'($urandom);
    c.use_remap = 1'($urandom);
    c.remap_base = $urandom;
    del_phase = ((n / 200) % 2) == 1;
    roll = $urandom_range(0, 99);
    if (roll < 5) c.operation = OP_UNUSED;
    else if (roll < 30) c.operation = OP_READ;
    else if (roll < (del_phase ? 70 : 45)) c.operation = OP_DELETE;
    else c.operation = OP_ADD;
    case (c.operation)
      OP_READ: begin
        if ($urandom_range(0, 7) == 0) c.window_index = 5'($urandom_range(20, 31));
        else c.window_index = 5'($urandom_range(0, NUM_WINDOWS - 1));
      end
      OP_DELETE: begin
        live = any_live_window();
        if (live >= 0 && $urandom_range(0, 3) != 0) begin
          c.base_addr = {win_base_g[live], 16'h0};
          c.window_size = granule_span(win_size_g[live]);
        end else if ($urandom_range(0, 1) == 0) begin
          c.base_addr = {6'($urandom_range(0, 63)), 26'h0} |
                        {14'h0, 2'($urandom_range(0, 3)), 16'h0};
          c.window_size = {16'($urandom_range(0, 47)), 16'h0} + 32'h10000;
        end
      end
      OP_ADD: begin
        if ($urandom_range(0, 9) != 0)
          c.base_addr = ($urandom_range(0, 63) << 26) | ($urandom & 32'h0003_ffff);
        roll = $urandom_range(0, 39);
        if (roll == 0) c.window_size = 32'h0;
        else if (roll == 1) c.window_size = 32'hffffffff;
        else if (roll > 3) c.window_size = $urandom_range(1, 32'h0030_0000);
        live = any_live_window();
        if (live >= 0 && $urandom_range(0, 5) == 0) begin
          c.target_id = win_tgt[live];
          c.attribute = win_attr[live];
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_beat(cmd_t c, bit typed, result_t r, int gap);
    result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predicted = table_outcome(c);
    pending_results.push_back(typed ? r : predicted);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        $error("Result beat with no command outstanding.");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("slot", 32'(want.slot), 32'(result.slot));
        check_field("entry_enabled", 32'(want.entry_enabled), 32'(result.entry_enabled));
        check_field("entry_base", want.entry_base, result.entry_base);
        check_field("entry_size", want.entry_size, result.entry_size);
        check_field("entry_target", 32'(want.entry_target), 32'(result.entry_target));
        check_field("entry_attribute", 32'(want.entry_attribute),
                    32'(result.entry_attribute));
        check_field("entry_remap", want.entry_remap, result.entry_remap);
      end
    end
  end

  initial begin
    bit   burst;
    int   gap;
    cmd_t c;
    burst = 1'b0;
    build_directed();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[k])
      send_beat(directed[k].c, directed[k].typed, directed[k].r, $urandom_range(0, 16));
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) burst = $urandom_range(0, 3) == 0;
      gap = burst ? 0 : $urandom_range(0, 16);
      c = random_beat(n);
      send_beat(c, 1'b0, '0, gap);
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
